FILE: rtl/core/gsa_pkg.sv
package gsa_pkg;

   localparam int OP_W     = 3;
   localparam int INDEX_W  = 8;
   localparam int GEN_W    = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 9;

   localparam logic [OP_W-1:0] OP_CREATE  = 3'd0;
   localparam logic [OP_W-1:0] OP_SET     = 3'd1;
   localparam logic [OP_W-1:0] OP_ASSIGN  = 3'd2;
   localparam logic [OP_W-1:0] OP_DESTROY = 3'd3;
   localparam logic [OP_W-1:0] OP_QUERY   = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

   typedef struct packed {
      logic             occupied;
      logic [GEN_W-1:0] generation;
      logic [GEN_W-1:0] revision;
   } slot_entry_type;

endpackage

FILE: rtl/core/gsa_bump.sv
module gsa_bump (
   input  logic [gsa_pkg::GEN_W-1:0] operand,
   output logic [gsa_pkg::GEN_W-1:0] result
);

   logic [gsa_pkg::GEN_W-1:0] sum;

   assign sum    = operand + gsa_pkg::GEN_W'(1);
   assign result = (sum == '0) ? gsa_pkg::GEN_W'(1) : sum;

endmodule

FILE: rtl/core/gsa_slot_store.sv
module gsa_slot_store #(
   parameter int SLOTS = 256
) (
   input  logic                    clock,
   input  logic                    rd_en,
   input  logic [$clog2(SLOTS)-1:0] rd_addr,
   output gsa_pkg::slot_entry_type rd_data,
   input  logic                    wr_en,
   input  logic [$clog2(SLOTS)-1:0] wr_addr,
   input  gsa_pkg::slot_entry_type wr_data
);

   gsa_pkg::slot_entry_type mem [SLOTS];
   gsa_pkg::slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/gsa_free_store.sv
module gsa_free_store #(
   parameter int SLOTS = 256
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(SLOTS)-1:0] rd_addr,
   output logic [$clog2(SLOTS)-1:0] rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(SLOTS)-1:0] wr_addr,
   input  logic [$clog2(SLOTS)-1:0] wr_data
);

   logic [$clog2(SLOTS)-1:0] mem [SLOTS];
   logic [$clog2(SLOTS)-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/generational_slot_allocator_top.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  operation, slot_index, handle_generation
// rsp       out        rsp_valid / rsp_stall  status, result_index, result_generation,
//                                             revision, alive, live_count
//
// A request passes two steps: the accept cycle reads the slot entry and the top of the
// free stack from synchronous memory, and the EVAL state then evaluates and writes back.
// A create that reuses a freed index adds a FILL state, since the popped index needs a second
// slot read and the slot memory has a single read port.
// Reset is synchronous and clears only the counters, the sequencer and the response valid.
// A new request is taken while a response waits; a stalled response holds the write-back.
module generational_slot_allocator_top #(
   parameter int SLOTS = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [gsa_pkg::OP_W-1:0]       req_operation,
   input  logic [gsa_pkg::INDEX_W-1:0]    req_slot_index,
   input  logic [gsa_pkg::GEN_W-1:0]      req_handle_generation,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [gsa_pkg::STATUS_W-1:0]   rsp_status,
   output logic [gsa_pkg::INDEX_W-1:0]    rsp_result_index,
   output logic [gsa_pkg::GEN_W-1:0]      rsp_result_generation,
   output logic [gsa_pkg::GEN_W-1:0]      rsp_revision,
   output logic                           rsp_alive,
   output logic [gsa_pkg::COUNT_W-1:0]    rsp_live_count
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int CMP_W = (CNT_W > gsa_pkg::INDEX_W) ? CNT_W : gsa_pkg::INDEX_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EVAL = 2'd1;
   localparam logic [1:0] ST_FILL = 2'd2;

   logic [1:0]                   state_ff, state_in;
   logic [CNT_W-1:0]             used_ff, used_in;
   logic [CNT_W-1:0]             free_ff, free_in;
   logic [CNT_W-1:0]             live_ff, live_in;
   logic [IDX_W-1:0]             pop_idx_ff, pop_idx_in;
   logic [gsa_pkg::OP_W-1:0]     op_ff;
   logic [gsa_pkg::INDEX_W-1:0]  idx_ff;
   logic [gsa_pkg::GEN_W-1:0]    hgen_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [gsa_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [gsa_pkg::INDEX_W-1:0]  rsp_index_ff;
   logic [gsa_pkg::GEN_W-1:0]    rsp_gen_ff;
   logic [gsa_pkg::GEN_W-1:0]    rsp_rev_ff;
   logic                         rsp_alive_ff;
   logic [gsa_pkg::COUNT_W-1:0]  rsp_live_ff;

   logic [gsa_pkg::STATUS_W-1:0] res_status;
   logic [gsa_pkg::INDEX_W-1:0]  res_index;
   logic [gsa_pkg::GEN_W-1:0]    res_gen;
   logic [gsa_pkg::GEN_W-1:0]    res_rev;
   logic                         res_alive;
   logic                         load;

   logic                         accept;
   logic                         out_busy;
   logic                         go_fill;
   logic                         handle_ok;
   logic                         is_create;
   logic [CNT_W-1:0]             free_top;

   logic                         slot_rd_en;
   logic [IDX_W-1:0]             slot_rd_addr;
   gsa_pkg::slot_entry_type      slot_rd;
   logic                         slot_wr_en;
   logic [IDX_W-1:0]             slot_wr_addr;
   gsa_pkg::slot_entry_type      slot_wr;

   logic [IDX_W-1:0]             free_rd;
   logic                         free_wr_en;

   logic [gsa_pkg::GEN_W-1:0]    bump_operand;
   logic [gsa_pkg::GEN_W-1:0]    bump_result;

   assign accept   = req_valid && !req_stall;
   assign out_busy = rsp_valid_ff && rsp_stall;
   assign free_top = free_ff - CNT_W'(1);

   assign slot_rd_en   = accept || go_fill;
   assign slot_rd_addr = accept ? IDX_W'(req_slot_index) : free_rd;

   assign handle_ok = (hgen_ff != '0)
                   && (CMP_W'(idx_ff) < CMP_W'(used_ff))
                   && slot_rd.occupied
                   && (slot_rd.generation == hgen_ff);
   assign is_create = (op_ff == gsa_pkg::OP_CREATE)
                   || ((op_ff == gsa_pkg::OP_ASSIGN) && !handle_ok);

   assign bump_operand = (op_ff == gsa_pkg::OP_DESTROY) ? slot_rd.generation
                                                        : slot_rd.revision;

   gsa_bump u_bump (
      .operand (bump_operand),
      .result  (bump_result)
   );

   gsa_slot_store #(.SLOTS(SLOTS)) u_slot_store (
      .clock   (clock),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr)
   );

   gsa_free_store #(.SLOTS(SLOTS)) u_free_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (free_top[IDX_W-1:0]),
      .rd_data (free_rd),
      .wr_en   (free_wr_en),
      .wr_addr (free_ff[IDX_W-1:0]),
      .wr_data (IDX_W'(idx_ff))
   );

   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      free_in      = free_ff;
      live_in      = live_ff;
      pop_idx_in   = pop_idx_ff;
      go_fill      = 1'b0;
      load         = 1'b0;
      slot_wr_en   = 1'b0;
      slot_wr_addr = IDX_W'(idx_ff);
      slot_wr      = '0;
      free_wr_en   = 1'b0;
      res_status   = gsa_pkg::STATUS_OK;
      res_index    = '0;
      res_gen      = '0;
      res_rev      = '0;
      res_alive    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (!out_busy) begin
               state_in = ST_IDLE;
               load     = 1'b1;
               if (is_create) begin
                  if (free_ff != '0) begin
                     pop_idx_in = free_rd;
                     go_fill    = 1'b1;
                     load       = 1'b0;
                     state_in   = ST_FILL;
                  end else if (used_ff != CNT_W'(SLOTS)) begin
                     slot_wr_en   = 1'b1;
                     slot_wr_addr = used_ff[IDX_W-1:0];
                     slot_wr      = '{occupied: 1'b1, generation: gsa_pkg::GEN_W'(1),
                                      revision: gsa_pkg::GEN_W'(1)};
                     used_in      = used_ff + CNT_W'(1);
                     live_in      = live_ff + CNT_W'(1);
                     res_index    = gsa_pkg::INDEX_W'(used_ff);
                     res_gen      = gsa_pkg::GEN_W'(1);
                     res_rev      = gsa_pkg::GEN_W'(1);
                     res_alive    = 1'b1;
                  end else begin
                     res_status = gsa_pkg::STATUS_FULL;
                  end
               end else begin
                  unique case (op_ff) inside
                     gsa_pkg::OP_SET, gsa_pkg::OP_ASSIGN: begin
                        if (handle_ok) begin
                           slot_wr_en = 1'b1;
                           slot_wr    = '{occupied: 1'b1, generation: slot_rd.generation,
                                          revision: bump_result};
                           res_index  = idx_ff;
                           res_gen    = hgen_ff;
                           res_rev    = bump_result;
                           res_alive  = 1'b1;
                        end else begin
                           res_status = gsa_pkg::STATUS_INVALID;
                        end
                     end
                     gsa_pkg::OP_DESTROY: begin
                        if (handle_ok) begin
                           slot_wr_en = 1'b1;
                           slot_wr    = '{occupied: 1'b0, generation: bump_result,
                                          revision: '0};
                           if (free_ff != CNT_W'(SLOTS)) begin
                              free_wr_en = 1'b1;
                              free_in    = free_ff + CNT_W'(1);
                           end
                           if (live_ff != '0) begin
                              live_in = live_ff - CNT_W'(1);
                           end
                           res_index = idx_ff;
                        end else begin
                           res_status = gsa_pkg::STATUS_INVALID;
                        end
                     end
                     gsa_pkg::OP_QUERY: begin
                        if (handle_ok) begin
                           res_index = idx_ff;
                           res_gen   = hgen_ff;
                           res_rev   = slot_rd.revision;
                           res_alive = 1'b1;
                        end else begin
                           res_status = gsa_pkg::STATUS_INVALID;
                        end
                     end
                     gsa_pkg::OP_CLEAR: begin
                        used_in = '0;
                        free_in = '0;
                        live_in = '0;
                     end
                     default: begin
                        res_status = gsa_pkg::STATUS_OK;
                     end
                  endcase
               end
            end
         end
         ST_FILL: begin
            if (!out_busy) begin
               state_in     = ST_IDLE;
               load         = 1'b1;
               slot_wr_en   = 1'b1;
               slot_wr_addr = pop_idx_ff;
               slot_wr      = '{occupied: 1'b1, generation: slot_rd.generation,
                                revision: gsa_pkg::GEN_W'(1)};
               free_in      = free_top;
               live_in      = live_ff + CNT_W'(1);
               res_index    = gsa_pkg::INDEX_W'(pop_idx_ff);
               res_gen      = slot_rd.generation;
               res_rev      = gsa_pkg::GEN_W'(1);
               res_alive    = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         free_ff      <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         free_ff      <= free_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pop_idx_ff <= pop_idx_in;
      if (accept) begin
         op_ff   <= req_operation;
         idx_ff  <= req_slot_index;
         hgen_ff <= req_handle_generation;
      end
      if (load) begin
         rsp_status_ff <= res_status;
         rsp_index_ff  <= res_index;
         rsp_gen_ff    <= res_gen;
         rsp_rev_ff    <= res_rev;
         rsp_alive_ff  <= res_alive;
         rsp_live_ff   <= gsa_pkg::COUNT_W'(live_in);
      end
   end

   assign req_stall             = (state_ff != ST_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_result_index      = rsp_index_ff;
   assign rsp_result_generation = rsp_gen_ff;
   assign rsp_revision          = rsp_rev_ff;
   assign rsp_alive             = rsp_alive_ff;
   assign rsp_live_count        = rsp_live_ff;

   a_slot_balance: assert property (@(posedge clock) disable iff (reset)
      (CNT_W + 1)'(live_ff) + (CNT_W + 1)'(free_ff) == (CNT_W + 1)'(used_ff))
      else $error("live and free slots do not add up to the slots in use");

   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EVAL))
      else $error("accepted request did not enter evaluation");

   a_fill_after_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) |-> ($past(state_ff) == ST_FILL || $past(go_fill)))
      else $error("fill state entered without a free stack pop");

endmodule

FILE: bench/slot_map_checker.sv
`timescale 1ns / 1ps

module slot_map_checker
   import gsa_pkg::*;
#(
   parameter int SLOTS = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [INDEX_W-1:0]  req_slot_index,
   input  logic [GEN_W-1:0]    req_handle_generation,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic [INDEX_W-1:0]  rsp_result_index,
   input  logic [GEN_W-1:0]    rsp_result_generation,
   input  logic [GEN_W-1:0]    rsp_revision,
   input  logic                rsp_alive,
   input  logic [COUNT_W-1:0]  rsp_live_count,
   output int                  mismatch_count,
   output int                  outstanding
);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  index;
      logic [GEN_W-1:0]    generation;
      logic [GEN_W-1:0]    revision;
      logic                alive;
      logic [COUNT_W-1:0]  live_count;
   } slot_response_t;

   bit                 occupied [SLOTS];
   bit [GEN_W-1:0]     generation_of [SLOTS];
   bit [GEN_W-1:0]     revision_of [SLOTS];
   bit [INDEX_W-1:0]   free_stack [SLOTS];
   int                 free_depth;
   int                 slots_used;
   int                 live_slots;
   slot_response_t     pending_responses [$];

   task automatic report_mismatch(input string what);
      $display("%0t slot_map_checker: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [GEN_W-1:0] got,
                              input logic [GEN_W-1:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
      end
   endtask

   function automatic slot_response_t make_response(input logic [STATUS_W-1:0] status,
                                                    input logic [INDEX_W-1:0] index,
                                                    input logic [GEN_W-1:0] generation,
                                                    input logic [GEN_W-1:0] revision,
                                                    input logic alive);
      slot_response_t res;
      res.status     = status;
      res.index      = index;
      res.generation = generation;
      res.revision   = revision;
      res.alive      = alive;
      res.live_count = live_slots[COUNT_W-1:0];
      return res;
   endfunction

   task automatic create_slot(output slot_response_t res);
      int i;
      if (free_depth > 0) begin
         free_depth--;
         i = free_stack[free_depth];
      end else if (slots_used < SLOTS) begin
         i = slots_used;
         slots_used++;
         generation_of[i] = 1;
      end else begin
         res = make_response(STATUS_FULL, '0, '0, '0, 1'b0);
         return;
      end
      occupied[i]    = 1'b1;
      revision_of[i] = 1;
      live_slots++;
      res = make_response(STATUS_OK, i[INDEX_W-1:0], generation_of[i], 1, 1'b1);
   endtask

   task automatic predict_slot_op(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                                  input logic [GEN_W-1:0] gen, output slot_response_t res);
      bit             handle_ok;
      bit [GEN_W-1:0] bumped;
      handle_ok = gen != 0 && int'(idx) < slots_used && occupied[idx]
                  && generation_of[idx] == gen;
      case (op)
         OP_CREATE: begin
            create_slot(res);
         end
         OP_SET, OP_ASSIGN: begin
            if (handle_ok) begin
               bumped = revision_of[idx] + 1;
               if (bumped == 0) begin
                  bumped = 1;
               end
               revision_of[idx] = bumped;
               res = make_response(STATUS_OK, idx, gen, bumped, 1'b1);
            end else if (op == OP_ASSIGN) begin
               create_slot(res);
            end else begin
               res = make_response(STATUS_INVALID, '0, '0, '0, 1'b0);
            end
         end
         OP_DESTROY: begin
            if (handle_ok) begin
               bumped = generation_of[idx] + 1;
               if (bumped == 0) begin
                  bumped = 1;
               end
               occupied[idx]      = 1'b0;
               revision_of[idx]   = 0;
               generation_of[idx] = bumped;
               if (free_depth < SLOTS) begin
                  free_stack[free_depth] = idx;
                  free_depth++;
               end
               if (live_slots > 0) begin
                  live_slots--;
               end
               res = make_response(STATUS_OK, idx, '0, '0, 1'b0);
            end else begin
               res = make_response(STATUS_INVALID, '0, '0, '0, 1'b0);
            end
         end
         OP_QUERY: begin
            if (handle_ok) begin
               res = make_response(STATUS_OK, idx, gen, revision_of[idx], 1'b1);
            end else begin
               res = make_response(STATUS_INVALID, '0, '0, '0, 1'b0);
            end
         end
         OP_CLEAR: begin
            slots_used = 0;
            free_depth = 0;
            live_slots = 0;
            res = make_response(STATUS_OK, '0, '0, '0, 1'b0);
         end
         default: begin
            res = make_response(STATUS_OK, '0, '0, '0, 1'b0);
         end
      endcase
   endtask

   always @(posedge clock) begin : watch
      slot_response_t want;
      slot_response_t got;
      if (reset) begin
         free_depth     = 0;
         slots_used     = 0;
         live_slots     = 0;
         mismatch_count = 0;
         pending_responses.delete();
         outstanding    = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_responses.size() == 0) begin
               report_mismatch("response arrived with no request waiting");
            end else begin
               want = pending_responses.pop_front();
               check_field("status", rsp_status, want.status);
               check_field("result_index", rsp_result_index, want.index);
               check_field("result_generation", rsp_result_generation, want.generation);
               check_field("revision", rsp_revision, want.revision);
               check_field("alive", rsp_alive, want.alive);
               check_field("live_count", rsp_live_count, want.live_count);
            end
         end
         if (req_valid && !req_stall) begin
            predict_slot_op(req_operation, req_slot_index, req_handle_generation, got);
            pending_responses.push_back(got);
         end
         outstanding = pending_responses.size();
      end
   end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
   import gsa_pkg::*;

   localparam int SLOTS       = 256;
   localparam int IDLE_LIMIT  = 1000;
   localparam int ITEM_TARGET = 700;
   localparam int HOLD_CYCLES = 80;
   localparam int HOLD_AFTER  = 150;

   localparam logic [OP_W-1:0]  OP_SPARE_LOW  = 3'd6;
   localparam logic [OP_W-1:0]  OP_SPARE_HIGH = 3'd7;
   localparam logic [GEN_W-1:0] GEN_ALL_ONES  = '1;

   typedef enum {PHASE_CHURN, PHASE_FILL, PHASE_DRAIN} phase_kind_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [OP_W-1:0]     req_operation = OP_CREATE;
   logic [INDEX_W-1:0]  req_slot_index = '0;
   logic [GEN_W-1:0]    req_handle_generation = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [INDEX_W-1:0]  rsp_result_index;
   logic [GEN_W-1:0]    rsp_result_generation;
   logic [GEN_W-1:0]    rsp_revision;
   logic                rsp_alive;
   logic [COUNT_W-1:0]  rsp_live_count;

   int mismatch_count;
   int outstanding;
   int requests_sent = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   int written_slots = 0;

   bit [GEN_W-1:0] known_generation [SLOTS];
   bit             known_live [SLOTS];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   generational_slot_allocator_top #(
      .SLOTS(SLOTS)
   ) i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_operation         (req_operation),
      .req_slot_index        (req_slot_index),
      .req_handle_generation (req_handle_generation),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_result_index      (rsp_result_index),
      .rsp_result_generation (rsp_result_generation),
      .rsp_revision          (rsp_revision),
      .rsp_alive             (rsp_alive),
      .rsp_live_count        (rsp_live_count)
   );

   slot_map_checker #(
      .SLOTS(SLOTS)
   ) i_checker (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_operation         (req_operation),
      .req_slot_index        (req_slot_index),
      .req_handle_generation (req_handle_generation),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_result_index      (rsp_result_index),
      .rsp_result_generation (rsp_result_generation),
      .rsp_revision          (rsp_revision),
      .rsp_alive             (rsp_alive),
      .rsp_live_count        (rsp_live_count),
      .mismatch_count        (mismatch_count),
      .outstanding           (outstanding)
   );

   // Live handles seen on the response side steer the stimulus toward valid handles.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall && rsp_status == STATUS_OK && rsp_alive) begin
         known_generation[rsp_result_index] = rsp_result_generation;
         known_live[rsp_result_index]       = 1'b1;
         if (int'(rsp_result_index) + 1 > written_slots) begin
            written_slots = int'(rsp_result_index) + 1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send_request(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                               input logic [GEN_W-1:0] gen);
      req_valid             <= 1'b1;
      req_operation         <= op;
      req_slot_index        <= idx;
      req_handle_generation <= gen;
      do begin
         @(posedge clock);
      end while (req_stall !== 1'b0);
      requests_sent++;
      if (op == OP_DESTROY) begin
         known_live[idx] = 1'b0;
      end
      if (op == OP_CLEAR) begin
         foreach (known_live[i]) begin
            known_live[i] = 1'b0;
         end
      end
   endtask

   task automatic issue(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                        input logic [GEN_W-1:0] gen);
      send_request(op, idx, gen);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(0, 30);
      end
   endtask

   task automatic wait_for_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic pick_handle(input int valid_pct, output logic [INDEX_W-1:0] idx,
                              output logic [GEN_W-1:0] gen);
      int start;
      int j;
      bit found;
      found = 1'b0;
      start = (written_slots > 0) ? $urandom_range(0, written_slots - 1) : 0;
      idx   = start[INDEX_W-1:0];
      if ($urandom_range(0, 99) < valid_pct) begin
         for (int k = 0; k < written_slots && !found; k++) begin
            j = (start + k) % written_slots;
            if (known_live[j]) begin
               idx   = j[INDEX_W-1:0];
               gen   = known_generation[j];
               found = 1'b1;
            end
         end
      end
      if (!found) begin
         case ($urandom_range(0, 5))
            0: gen = '0;
            1: gen = known_generation[idx];
            2: gen = known_generation[idx] - 1;
            3: gen = known_generation[idx] + 1;
            4: gen = $urandom;
            default: gen = GEN_ALL_ONES;
         endcase
      end
   endtask

   task automatic run_phase(input phase_kind_t kind, input int count);
      int                 w;
      logic [OP_W-1:0]    op;
      logic [INDEX_W-1:0] idx;
      logic [GEN_W-1:0]   gen;
      repeat (count) begin
         w = $urandom_range(0, 99);
         pick_handle(85, idx, gen);
         case (kind)
            PHASE_FILL: begin
               if (w < 85) begin
                  op = OP_CREATE;
               end else if (w < 90) begin
                  op  = OP_ASSIGN;
                  gen = '0;
               end else if (w < 95) begin
                  op = OP_QUERY;
               end else begin
                  op = OP_SET;
               end
            end
            PHASE_DRAIN: begin
               if (w < 60) begin
                  op = OP_DESTROY;
               end else if (w < 80) begin
                  op = OP_QUERY;
               end else if (w < 90) begin
                  op = OP_SET;
               end else begin
                  op = OP_CREATE;
               end
            end
            default: begin
               if (w < 15) begin
                  op = OP_CREATE;
               end else if (w < 35) begin
                  op = OP_SET;
               end else if (w < 50) begin
                  op = OP_ASSIGN;
               end else if (w < 65) begin
                  op = OP_DESTROY;
               end else if (w < 90) begin
                  op = OP_QUERY;
               end else begin
                  op = $urandom_range(0, 7);
                  pick_handle(30, idx, gen);
               end
            end
         endcase
         issue(op, idx, gen);
      end
   endtask

   initial begin
      int w;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      issue(OP_CREATE, 8'd0, '0);
      issue(OP_CREATE, 8'd0, '0);
      issue(OP_CREATE, 8'd0, '0);
      issue(OP_QUERY, 8'd1, 32'd1);
      issue(OP_SET, 8'd1, 32'd1);
      issue(OP_ASSIGN, 8'd2, 32'd1);
      issue(OP_ASSIGN, 8'd0, 32'd5);
      issue(OP_DESTROY, 8'd1, 32'd1);
      issue(OP_QUERY, 8'd1, 32'd1);
      issue(OP_DESTROY, 8'd1, 32'd1);
      issue(OP_SET, 8'd0, '0);
      issue(OP_QUERY, 8'd2, GEN_ALL_ONES);
      issue(OP_DESTROY, 8'd2, 32'd1);
      issue(OP_CREATE, 8'd3, GEN_ALL_ONES);
      issue(OP_CREATE, 8'd0, '0);
      issue(OP_QUERY, 8'd1, 32'd2);
      issue(OP_SET, 8'd2, 32'd2);
      issue(OP_SPARE_LOW, 8'd0, '0);
      issue(OP_SPARE_HIGH, 8'd3, GEN_ALL_ONES);
      issue(OP_SET, 8'd3, 32'd1);
      issue(OP_CLEAR, 8'd0, '0);
      issue(OP_QUERY, 8'd0, 32'd1);
      issue(OP_CREATE, 8'd0, '0);
      wait_for_responses();

      run_phase(PHASE_FILL, 300);
      while (requests_sent < ITEM_TARGET) begin
         w = $urandom_range(0, 99);
         if (w < 8) begin
            issue(OP_CLEAR, $urandom_range(0, written_slots - 1), $urandom);
            wait_for_responses();
         end else if (w < 18) begin
            wait_for_responses();
         end else if (w < 55) begin
            run_phase(PHASE_CHURN, $urandom_range(15, 60));
         end else if (w < 80) begin
            run_phase(PHASE_DRAIN, $urandom_range(15, 60));
         end else begin
            run_phase(PHASE_FILL, $urandom_range(15, 60));
         end
      end

      wait_for_responses();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      bit hold_done;
      int span;
      int mode;
      hold_done = 1'b0;
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         if (!hold_done && requests_sent >= HOLD_AFTER) begin
            hold_done = 1'b1;
            repeat (HOLD_CYCLES) begin
               @(posedge clock);
               rsp_stall <= 1'b1;
            end
         end else begin
            span = $urandom_range(5, 40);
            mode = $urandom_range(0, 2);
            repeat (span) begin
               @(posedge clock);
               case (mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(0, 3) == 0);
                  default: rsp_stall <= $urandom_range(0, 1);
               endcase
            end
         end
      end
   end

endmodule
